[hdl/spit_pkg.sv]
package spit_pkg;

  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;

  localparam int DIFF_W = 33;
  localparam int SQP_W  = 66;
  localparam int A_W    = 66;
  localparam int B_W    = 68;
  localparam int C_W    = 67;
  localparam int MUL_W  = 68;
  localparam int DISC_W = 2 * MUL_W;
  localparam int ROOT_W = DISC_W / 2;
  localparam int SUM_W  = 70;
  localparam int D_W    = A_W + 1;
  localparam int Q_W    = 33;
  localparam int T_W    = Q_W + 2;
  localparam int CMP_W  = 44;

  localparam logic [31:0] T_SAT = 32'h7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS_A   = 2'd0,
    REG_RADIUS_B   = 2'd1,
    REG_FRAME_TIME = 2'd2
  } spit_reg_e;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_a_z;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_a_z;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] pos_b_z;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic signed [31:0] vel_b_z;
  } spit_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] collision_time;
  } spit_out_t;

endpackage

[hdl/spit_mul.sv]
module spit_mul #(
  parameter int W      = 68,
  parameter int SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  vld_o,
  output logic signed [2*W-1:0] p_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int H = (W + 1) / 2;
  localparam int L = W - H;

  logic [4:0]         vld_q;
  logic [SIDE_W-1:0]  side_q [5];
  logic [3:0]         neg_q;
  logic [W-1:0]       ma_q, mb_q;
  logic [2*H-1:0]     ll_q;
  logic [H+L-1:0]     lh_q, hl_q;
  logic [2*L-1:0]     hh_q;
  logic [2*W-1:0]     x_q;
  logic [H+L:0]       y_q;
  logic [2*W-1:0]     mag_q;
  logic signed [2*W-1:0] p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int i = 1; i < 5; i++) begin
        side_q[i] <= side_q[i-1];
      end
      neg_q <= {neg_q[2:0], a_i[W-1] ^ b_i[W-1]};
      ma_q  <= a_i[W-1] ? W'(-a_i) : a_i;
      mb_q  <= b_i[W-1] ? W'(-b_i) : b_i;
      ll_q  <= ma_q[H-1:0] * mb_q[H-1:0];
      lh_q  <= ma_q[H-1:0] * mb_q[W-1:H];
      hl_q  <= ma_q[W-1:H] * mb_q[H-1:0];
      hh_q  <= ma_q[W-1:H] * mb_q[W-1:H];
      x_q   <= {hh_q, ll_q};
      y_q   <= (H+L+1)'(lh_q) + (H+L+1)'(hl_q);
      mag_q <= x_q + ((2*W)'(y_q) << H);
      p_q   <= neg_q[3] ? -$signed(mag_q) : $signed(mag_q);
    end
  end

  assign vld_o  = vld_q[4];
  assign p_o    = p_q;
  assign side_o = side_q[4];

endmodule

[hdl/spit_isqrt.sv]
module spit_isqrt #(
  parameter int XW     = 136,
  parameter int SIDE_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [XW-1:0]      x_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               vld_o,
  output logic [XW/2-1:0]    root_o,
  output logic [SIDE_W-1:0]  side_o
);

  localparam int RW  = XW / 2;
  localparam int RMW = RW + 2;

  logic [XW-1:0]     x_w    [RW+1];
  logic [RMW-1:0]    rem_w  [RW+1];
  logic [RW-1:0]     root_w [RW+1];
  logic [SIDE_W-1:0] side_w [RW+1];
  logic              vld_w  [RW+1];

  assign x_w[0]    = x_i;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign side_w[0] = side_i;
  assign vld_w[0]  = vld_i;

  for (genvar g = 0; g < RW; g++) begin : g_step
    logic [XW-1:0]     x_q;
    logic [RMW-1:0]    rem_q;
    logic [RW-1:0]     root_q;
    logic [SIDE_W-1:0] side_q;
    logic              vld_q;
    logic [RMW+1:0]    rem_sh;
    logic [RMW+1:0]    trial;
    logic              ge;

    assign rem_sh = {rem_w[g], x_w[g][XW-1 -: 2]};
    assign trial  = (RMW+2)'({root_w[g], 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q    <= x_w[g] << 2;
        rem_q  <= ge ? RMW'(rem_sh - trial) : RMW'(rem_sh);
        root_q <= {root_w[g][RW-2:0], ge};
        side_q <= side_w[g];
      end
    end

    assign x_w[g+1]    = x_q;
    assign rem_w[g+1]  = rem_q;
    assign root_w[g+1] = root_q;
    assign side_w[g+1] = side_q;
    assign vld_w[g+1]  = vld_q;
  end

  assign vld_o  = vld_w[RW];
  assign root_o = root_w[RW];
  assign side_o = side_w[RW];

endmodule

[hdl/spit_div.sv]
module spit_div #(
  parameter int MW     = 85,
  parameter int DW     = 67,
  parameter int QW     = 33,
  parameter int SIDE_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [MW-1:0]      m_i,
  input  logic [DW-1:0]      d_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               vld_o,
  output logic [QW-1:0]      q_o,
  output logic               rem_nz_o,
  output logic               big_o,
  output logic [SIDE_W-1:0]  side_o
);

  localparam int HW = MW - QW;
  localparam int EW = (HW > DW) ? HW : DW;

  logic [EW-1:0] hi_e, d_e;

  logic [DW-1:0]     rem_w  [QW+1];
  logic [QW-1:0]     q_w    [QW+1];
  logic [QW-1:0]     ml_w   [QW+1];
  logic [DW-1:0]     d_w    [QW+1];
  logic              big_w  [QW+1];
  logic [SIDE_W-1:0] side_w [QW+1];
  logic              vld_w  [QW+1];

  logic [DW-1:0]     rem0_q, d0_q;
  logic [QW-1:0]     ml0_q;
  logic              big0_q, vld0_q;
  logic [SIDE_W-1:0] side0_q;

  assign hi_e = EW'(m_i[MW-1:QW]);
  assign d_e  = EW'(d_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      big0_q  <= hi_e >= d_e;
      rem0_q  <= DW'(hi_e);
      ml0_q   <= m_i[QW-1:0];
      d0_q    <= d_i;
      side0_q <= side_i;
    end
  end

  assign rem_w[0]  = rem0_q;
  assign q_w[0]    = '0;
  assign ml_w[0]   = ml0_q;
  assign d_w[0]    = d0_q;
  assign big_w[0]  = big0_q;
  assign side_w[0] = side0_q;
  assign vld_w[0]  = vld0_q;

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic [DW-1:0]     rem_q, d_q;
    logic [QW-1:0]     q_q, ml_q;
    logic              big_q, vld_q;
    logic [SIDE_W-1:0] side_q;
    logic [DW:0]       rem_sh;
    logic              ge;

    assign rem_sh = {rem_w[g], ml_w[g][QW-1]};
    assign ge     = rem_sh >= {1'b0, d_w[g]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= ge ? DW'(rem_sh - {1'b0, d_w[g]}) : DW'(rem_sh);
        q_q    <= {q_w[g][QW-2:0], ge};
        ml_q   <= ml_w[g] << 1;
        d_q    <= d_w[g];
        big_q  <= big_w[g];
        side_q <= side_w[g];
      end
    end

    assign rem_w[g+1]  = rem_q;
    assign q_w[g+1]    = q_q;
    assign ml_w[g+1]   = ml_q;
    assign d_w[g+1]    = d_q;
    assign big_w[g+1]  = big_q;
    assign side_w[g+1] = side_q;
    assign vld_w[g+1]  = vld_q;
  end

  assign vld_o    = vld_w[QW];
  assign q_o      = q_w[QW];
  assign rem_nz_o = |rem_w[QW];
  assign big_o    = big_w[QW];
  assign side_o   = side_w[QW];

endmodule

[hdl/sphere_pair_impact_time_top.sv]
// Throughput: one pair per cycle; every stage advances together and the
// whole pipeline holds while a result waits for out_ready_i.
// Reset: asynchronous, active low; clears all valid bits and the radius and
// frame time registers.
module sphere_pair_impact_time_top import spit_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  spit_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output spit_out_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int M_W = SUM_W - 1 + FRAC_BITS;
  localparam logic [A_W-1:0] AMIN =
    A_W'(((64'd1 << (2 * FRAC_BITS)) + 64'd999999) / 64'd1000000);
  localparam int LO = (1 << FRAC_BITS) / 100;
  localparam logic signed [T_W-1:0] T_LO  = T_W'(-LO);
  localparam logic signed [T_W-1:0] T_MAX = T_W'(T_SAT);

  logic en;

  logic [CFG_W-1:0] radius_a_q, radius_b_q, frame_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_a_q   <= '0;
      radius_b_q   <= '0;
      frame_time_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RADIUS_A:   radius_a_q   <= cfg_data_i;
        REG_RADIUS_B:   radius_b_q   <= cfg_data_i;
        REG_FRAME_TIME: frame_time_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // relative position and velocity
  logic                     v1_q;
  logic signed [DIFF_W-1:0] dp_q [3];
  logic signed [DIFF_W-1:0] dv_q [3];
  logic [31:0]              r_q;

  // squares and dot products
  logic                    v2_q;
  logic signed [SQP_W-1:0] pa_q [3];
  logic signed [SQP_W-1:0] pb_q [3];
  logic signed [SQP_W-1:0] pc_q [3];
  logic [63:0]             rr_q;

  // quadratic coefficients
  logic                  v3_q;
  logic [A_W-1:0]        a_q;
  logic signed [B_W-1:0] b_q;
  logic signed [C_W-1:0] c_q;
  logic signed [B_W-1:0] bs;

  always_comb begin
    bs = B_W'(pb_q[0]) + B_W'(pb_q[1]) + B_W'(pb_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dp_q[0] <= {in_data_i.pos_a_x[31], in_data_i.pos_a_x}
               - {in_data_i.pos_b_x[31], in_data_i.pos_b_x};
      dp_q[1] <= {in_data_i.pos_a_y[31], in_data_i.pos_a_y}
               - {in_data_i.pos_b_y[31], in_data_i.pos_b_y};
      dp_q[2] <= {in_data_i.pos_a_z[31], in_data_i.pos_a_z}
               - {in_data_i.pos_b_z[31], in_data_i.pos_b_z};
      dv_q[0] <= {in_data_i.vel_a_x[31], in_data_i.vel_a_x}
               - {in_data_i.vel_b_x[31], in_data_i.vel_b_x};
      dv_q[1] <= {in_data_i.vel_a_y[31], in_data_i.vel_a_y}
               - {in_data_i.vel_b_y[31], in_data_i.vel_b_y};
      dv_q[2] <= {in_data_i.vel_a_z[31], in_data_i.vel_a_z}
               - {in_data_i.vel_b_z[31], in_data_i.vel_b_z};
      r_q     <= 32'(radius_a_q) + 32'(radius_b_q);
      for (int k = 0; k < 3; k++) begin
        pa_q[k] <= dv_q[k] * dv_q[k];
        pb_q[k] <= dv_q[k] * dp_q[k];
        pc_q[k] <= dp_q[k] * dp_q[k];
      end
      rr_q <= r_q * r_q;
      a_q  <= A_W'(pa_q[0]) + A_W'(pa_q[1]) + A_W'(pa_q[2]);
      b_q  <= bs <<< 1;
      c_q  <= C_W'(pc_q[0]) + C_W'(pc_q[1]) + C_W'(pc_q[2]) - C_W'(rr_q);
    end
  end

  // b^2 and a*c
  logic                       bb_vld, ac_vld;
  logic signed [2*MUL_W-1:0]  bb_p, ac_p;
  logic [A_W+B_W-1:0]         bb_side;
  logic                       ac_nohit;

  spit_mul #(.W(MUL_W), .SIDE_W(A_W + B_W)) u_mul_bb (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v3_q),
    .a_i    (b_q),
    .b_i    (b_q),
    .side_i ({a_q, b_q}),
    .vld_o  (bb_vld),
    .p_o    (bb_p),
    .side_o (bb_side)
  );

  spit_mul #(.W(MUL_W), .SIDE_W(1)) u_mul_ac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v3_q),
    .a_i    (MUL_W'(a_q)),
    .b_i    (MUL_W'(c_q)),
    .side_i (a_q < AMIN),
    .vld_o  (ac_vld),
    .p_o    (ac_p),
    .side_o (ac_nohit)
  );

  // discriminant
  logic signed [DISC_W-1:0] disc;
  logic                     vd_q, nohit_d_q;
  logic [DISC_W-1:0]        x_q;
  logic [A_W-1:0]           a_d_q;
  logic signed [B_W-1:0]    b_d_q;

  assign disc = bb_p - (ac_p <<< 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en) begin
      vd_q <= bb_vld & ac_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nohit_d_q <= ac_nohit | disc[DISC_W-1];
      x_q       <= (ac_nohit | disc[DISC_W-1]) ? '0 : disc;
      a_d_q     <= bb_side[A_W+B_W-1:B_W];
      b_d_q     <= bb_side[B_W-1:0];
    end
  end

  // square root
  logic                  sq_vld;
  logic [ROOT_W-1:0]     root;
  logic [A_W+B_W:0]      sq_side;

  spit_isqrt #(.XW(DISC_W), .SIDE_W(A_W + B_W + 1)) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vd_q),
    .x_i    (x_q),
    .side_i ({nohit_d_q, a_d_q, b_d_q}),
    .vld_o  (sq_vld),
    .root_o (root),
    .side_o (sq_side)
  );

  // numerator: -(b + s) scaled
  logic                    vn1_q, vn2_q;
  logic [SUM_W-1:0]        sum_q;
  logic [D_W-1:0]          d1_q, d2_q;
  logic                    nohit1_q, nohit2_q, neg_q;
  logic [M_W-1:0]          m_q;
  logic [SUM_W-2:0]        mag;

  assign mag = sum_q[SUM_W-1] ? (SUM_W-1)'(-sum_q) : sum_q[SUM_W-2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn1_q <= 1'b0;
      vn2_q <= 1'b0;
    end else if (en) begin
      vn1_q <= sq_vld;
      vn2_q <= vn1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q    <= {{(SUM_W-B_W){sq_side[B_W-1]}}, sq_side[B_W-1:0]}
                + SUM_W'(root);
      d1_q     <= {sq_side[A_W+B_W-1:B_W], 1'b0};
      nohit1_q <= sq_side[A_W+B_W];
      neg_q    <= !sum_q[SUM_W-1] && (sum_q != '0);
      m_q      <= {mag, {FRAC_BITS{1'b0}}};
      d2_q     <= d1_q;
      nohit2_q <= nohit1_q;
    end
  end

  // division
  logic           dv_vld, rem_nz, big;
  logic [Q_W-1:0] q;
  logic [1:0]     dv_side;

  spit_div #(.MW(M_W), .DW(D_W), .QW(Q_W), .SIDE_W(2)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (vn2_q),
    .m_i      (m_q),
    .d_i      (d2_q),
    .side_i   ({nohit2_q, neg_q}),
    .vld_o    (dv_vld),
    .q_o      (q),
    .rem_nz_o (rem_nz),
    .big_o    (big),
    .side_o   (dv_side)
  );

  // time, window and output
  logic                    vf1_q, vf2_q;
  logic signed [T_W-1:0]   t_q;
  logic [T_W-1:0]          tq;
  logic                    kill1_q, kill2_q, ge_lo_q, sat_q;
  logic [31:0]             tlow_q;
  logic signed [CMP_W-1:0] te, fe, t100_q, ft101_q;
  logic                    hit;
  logic                    out_valid_q;
  spit_out_t               out_q;

  assign tq  = {2'b00, q};
  assign te  = CMP_W'(t_q);
  assign fe  = CMP_W'(frame_time_q);
  assign hit = !kill2_q && ge_lo_q && (t100_q <= ft101_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf1_q       <= 1'b0;
      vf2_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vf1_q       <= dv_vld;
      vf2_q       <= vf1_q;
      out_valid_q <= vf2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q     <= dv_side[0] ? (rem_nz ? ~tq : -tq) : tq;
      kill1_q <= dv_side[1] | big;
      t100_q  <= (te <<< 6) + (te <<< 5) + (te <<< 2);
      ft101_q <= (fe <<< 6) + (fe <<< 5) + (fe <<< 2) + fe;
      ge_lo_q <= t_q >= T_LO;
      sat_q   <= t_q > T_MAX;
      tlow_q  <= t_q[31:0];
      kill2_q <= kill1_q;
      out_q.hit            <= hit;
      out_q.collision_time <= hit ? (sat_q ? T_SAT : tlow_q) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/spit_chk.sv]
module spit_chk import spit_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input spit_out_t out_data_o
);

  localparam logic signed [31:0] T_LO = 32'(-((1 << FRAC_BITS) / 100));

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without output stall");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.collision_time == 32'sd0)
    else $error("nonzero time without hit");

  a_hit_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.collision_time >= T_LO)
    else $error("hit time below window");

endmodule

bind sphere_pair_impact_time_top spit_chk #(.FRAC_BITS(FRAC_BITS)) u_spit_chk (.*);
